[hdl/krct_pkg.sv]
// Shared types and constants for the keyed region cache table.
// Operation, status and refusal codes, the controller/datapath interface structs.
// No dependencies.
package krct_pkg;

	localparam int KEY_W   = 64;
	localparam int COST_W  = 24;
	localparam int WORD_W  = 32;
	localparam int SLOT_W  = 6;

	// operation codes carried by kind
	localparam logic [1:0] KIND_STORE = 2'd0;
	localparam logic [1:0] KIND_FIND  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_MISS     = 3'd2;
	localparam logic [2:0] ST_NOCACHE  = 3'd3;
	localparam logic [2:0] ST_BADKEY   = 3'd4;
	localparam logic [2:0] ST_OVERCAP  = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;

	// refusal reason codes
	localparam logic [1:0] REF_NONE    = 2'd0;
	localparam logic [1:0] REF_NOCACHE = 2'd1;
	localparam logic [1:0] REF_BADKEY  = 2'd2;
	localparam logic [1:0] REF_OVERCAP = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load_item;
		logic scan_step;
		logic commit;
	} krct_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic match;
		logic scan_more;
		logic rd_pend;
		logic out_free;
	} krct_sts_t;

	// saturating 32-bit increment
	function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
		return (v == '1) ? v : v + WORD_W'(1);
	endfunction

endpackage

[hdl/keyed_region_cache_table.sv]
// Top level of the keyed region cache table: store, find and clear on a keyed directory.
// Depends on krct_pkg, krct_ctrl, krct_dp (which holds krct_ram).
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_stall    | kind, key, cost, cacheable
//  out      | out_valid / out_stall  | status, slot, last_refusal, bytes_used,
//           |                        | hit_count, miss_count, refusal_count
//  cfg      | cfg_wr_en              | cfg_wr_data (byte_capacity)
//
// One item at a time: an item is accepted, its key is compared against the stored keys
// through the key memory's one read port, and its result is committed to the result
// register; the scan stops early when the key is found, and the next item is taken
// only after the commit.
// Reset clears the entry count, byte total, refusal reason, counters and capacity;
// the key memory is not cleared, and no clearing pass runs after reset.
// A held result in the output register does not block accepting the next item; the
// finished item waits in the controller until the output register frees up.
module keyed_region_cache_table #(
	parameter int ENTRY_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [krct_pkg::WORD_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   kind,
	input  logic [krct_pkg::KEY_W-1:0]   key,
	input  logic [krct_pkg::COST_W-1:0]  cost,
	input  logic                         cacheable,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	output logic [krct_pkg::SLOT_W-1:0]  slot,
	output logic [1:0]                   last_refusal,
	output logic [krct_pkg::WORD_W-1:0]  bytes_used,
	output logic [krct_pkg::WORD_W-1:0]  hit_count,
	output logic [krct_pkg::WORD_W-1:0]  miss_count,
	output logic [krct_pkg::WORD_W-1:0]  refusal_count
);
	import krct_pkg::*;

	krct_cmd_t cmd;
	krct_sts_t sts;

	krct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	krct_dp #(
		.ENTRY_SLOTS(ENTRY_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.kind          (kind),
		.key           (key),
		.cost          (cost),
		.cacheable     (cacheable),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot          (slot),
		.last_refusal  (last_refusal),
		.bytes_used    (bytes_used),
		.hit_count     (hit_count),
		.miss_count    (miss_count),
		.refusal_count (refusal_count)
	);

endmodule

[hdl/krct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module krct_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/krct_ctrl.sv]
// Controller state machine for the keyed region cache table.
// Depends on krct_pkg for the command and status structs.
module krct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  krct_pkg::krct_sts_t sts,
	output krct_pkg::krct_cmd_t cmd
);
	import krct_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.match || (!sts.scan_more && !sts.rd_pend)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/krct_dp.sv]
// Datapath for the keyed region cache table: item latch, key memory scan,
// directory state, counters and the result register. Depends on krct_pkg, krct_ram.
module krct_dp #(
	parameter int ENTRY_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  krct_pkg::krct_cmd_t          cmd,
	output krct_pkg::krct_sts_t          sts,
	input  logic                         cfg_wr_en,
	input  logic [krct_pkg::WORD_W-1:0]  cfg_wr_data,
	input  logic [1:0]                   kind,
	input  logic [krct_pkg::KEY_W-1:0]   key,
	input  logic [krct_pkg::COST_W-1:0]  cost,
	input  logic                         cacheable,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	output logic [krct_pkg::SLOT_W-1:0]  slot,
	output logic [1:0]                   last_refusal,
	output logic [krct_pkg::WORD_W-1:0]  bytes_used,
	output logic [krct_pkg::WORD_W-1:0]  hit_count,
	output logic [krct_pkg::WORD_W-1:0]  miss_count,
	output logic [krct_pkg::WORD_W-1:0]  refusal_count
);
	import krct_pkg::*;

	localparam int IDX_W = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
	localparam int CNT_W = $clog2(ENTRY_SLOTS + 1);

	// latched item
	logic [1:0]        kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [COST_W-1:0] cost_q;
	logic              cacheable_q;

	// directory state
	logic [WORD_W-1:0] capacity_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] total_q;
	logic [1:0]        reason_q;
	logic [WORD_W-1:0] hits_q;
	logic [WORD_W-1:0] misses_q;
	logic [WORD_W-1:0] refusals_q;

	// scan
	logic [CNT_W-1:0]  scan_idx_q;
	logic              rd_pend_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [KEY_W-1:0]  rd_data;
	logic              found_q;
	logic [IDX_W-1:0]  found_idx_q;
	logic              match;

	// result register
	logic              out_valid_q;
	logic              out_free;

	// commit results
	logic [CNT_W-1:0]  count_d;
	logic [WORD_W-1:0] total_d;
	logic [1:0]        reason_d;
	logic [WORD_W-1:0] hits_d;
	logic [WORD_W-1:0] misses_d;
	logic [WORD_W-1:0] refusals_d;
	logic [2:0]        status_d;
	logic [IDX_W-1:0]  slot_idx_d;
	logic              wr_en;
	logic [WORD_W:0]   sum;
	logic              over_cap;
	logic              table_full;
	logic [IDX_W+SLOT_W-1:0] slot_wide;

	krct_ram #(
		.WIDTH(KEY_W),
		.DEPTH(ENTRY_SLOTS)
	) u_keys (
		.clk   (clk),
		.we    (cmd.commit && wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (key_q),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	assign match    = rd_pend_s1 && (rd_data == key_q);
	assign out_free = !out_valid_q || !out_stall;

	assign sts.match     = match;
	assign sts.scan_more = (scan_idx_q < count_q);
	assign sts.rd_pend   = rd_pend_s1;
	assign sts.out_free  = out_free;

	// latch the item when accepted
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q      <= kind;
			key_q       <= key;
			cost_q      <= cost;
			cacheable_q <= cacheable;
		end
	end

	// walk the stored keys, one read per cycle, compare the read data in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else if (cmd.load_item) begin
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else if (cmd.scan_step) begin
			rd_pend_s1 <= sts.scan_more;
			if (sts.scan_more) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			if (match && !found_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
			if (match && !found_q) begin
				found_idx_q <= rd_idx_s1;
			end
		end
	end

	assign sum        = {1'b0, total_q} + (WORD_W + 1)'(cost_q);
	assign over_cap   = (capacity_q != '0) && (sum > {1'b0, capacity_q});
	assign table_full = (count_q >= CNT_W'(ENTRY_SLOTS));

	// decide the operation outcome
	always_comb begin
		count_d    = count_q;
		total_d    = total_q;
		reason_d   = reason_q;
		hits_d     = hits_q;
		misses_d   = misses_q;
		refusals_d = refusals_q;
		status_d   = ST_OK;
		slot_idx_d = '0;
		wr_en      = 1'b0;
		unique case (kind_q)
			KIND_STORE: begin
				priority if (!cacheable_q) begin
					reason_d   = REF_NOCACHE;
					refusals_d = sat_inc(refusals_q);
					status_d   = ST_NOCACHE;
				end else if (key_q == '0) begin
					reason_d   = REF_BADKEY;
					refusals_d = sat_inc(refusals_q);
					status_d   = ST_BADKEY;
				end else if (found_q) begin
					status_d   = ST_PRESENT;
					slot_idx_d = found_idx_q;
				end else if (over_cap) begin
					reason_d   = REF_OVERCAP;
					refusals_d = sat_inc(refusals_q);
					status_d   = ST_OVERCAP;
				end else if (table_full) begin
					status_d   = ST_FULL;
				end else begin
					wr_en      = 1'b1;
					slot_idx_d = count_q[IDX_W-1:0];
					count_d    = count_q + CNT_W'(1);
					total_d    = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
					reason_d   = REF_NONE;
					status_d   = ST_OK;
				end
			end
			KIND_FIND: begin
				if (found_q) begin
					hits_d     = sat_inc(hits_q);
					status_d   = ST_PRESENT;
					slot_idx_d = found_idx_q;
				end else begin
					misses_d   = sat_inc(misses_q);
					status_d   = ST_MISS;
				end
			end
			KIND_CLEAR: begin
				count_d  = '0;
				total_d  = '0;
				reason_d = REF_NONE;
			end
			default: begin
			end
		endcase
	end

	assign slot_wide = (IDX_W + SLOT_W)'(slot_idx_d);

	// directory state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			count_q    <= '0;
			total_q    <= '0;
			reason_q   <= REF_NONE;
			hits_q     <= '0;
			misses_q   <= '0;
			refusals_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				count_q    <= count_d;
				total_q    <= total_d;
				reason_q   <= reason_d;
				hits_q     <= hits_d;
				misses_q   <= misses_d;
				refusals_q <= refusals_d;
			end
		end
	end

	// result valid: set on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, values after the update
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status        <= status_d;
			slot          <= slot_wide[SLOT_W-1:0];
			last_refusal  <= reason_d;
			bytes_used    <= total_d;
			hit_count     <= hits_d;
			miss_count    <= misses_d;
			refusal_count <= refusals_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule
